// ----- hw/rtl/fair_counting_semaphore_macros.svh -----
// Assertion macros shared by the semaphore checker.
`ifndef FAIR_COUNTING_SEMAPHORE_MACROS_SVH
`define FAIR_COUNTING_SEMAPHORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fcs_pkg.sv -----
// Package with the sizes, codes and types shared by the semaphore modules.
package fcs_pkg;

  // Queue depth and counter width.
  localparam int MAX_WAITERS = 16;
  localparam int COUNT_BITS  = 16;

  // Field widths of the request and result transfers.
  localparam int ID_W      = 4;
  localparam int STATUS_W  = 3;
  localparam int WAITING_W = 5;
  localparam int CFG_W     = 16;

  // Queue pointer and fill widths follow the queue depth.
  localparam int PTR_W  = $clog2(MAX_WAITERS);
  localparam int FILL_W = $clog2(MAX_WAITERS + 1);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CFG_W-1:0]      INIT_RESET = CFG_W'(1);

  // Request kinds.
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    RES_GRANTED = 3'd0,
    RES_QUEUED  = 3'd1,
    RES_PASSED  = 3'd2,
    RES_INCR    = 3'd3,
    RES_FULL    = 3'd4,
    RES_AT_MAX  = 3'd5
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    exec;
    logic    dec;
    logic    inc;
    logic    push;
    logic    pop;
    result_t result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_type;
    logic count_zero;
    logic count_max;
    logic queue_full;
    logic queue_empty;
  } dp_flags_t;

  // Load value for the counter: saturates when the counter is narrower.
  function automatic logic [COUNT_BITS-1:0] load_count(input logic [CFG_W-1:0] v);
    logic [COUNT_BITS-1:0] res;
    begin
      if (COUNT_BITS >= CFG_W) begin
        res = COUNT_BITS'(v);
      end else if (v > CFG_W'(CNT_MAX)) begin
        res = CNT_MAX;
      end else begin
        res = COUNT_BITS'(v);
      end
      return res;
    end
  endfunction

endpackage

// ----- hw/rtl/fair_counting_semaphore.sv -----
// Top level of the fair counting semaphore: register port, controller and datapath.
//
// One request (acquire or release) is accepted when start is high and busy
// is low. The controller decides the request in its execute state against the
// registered count and queue state, so busy is high for the cycle after the
// accepted transfer and no new request is taken until that decision is made. The
// result shows on status, grant_id, waiting and count_now, registered from the
// execute state, with done high for exactly one cycle; there is no way to hold
// it, so the receiver must take it in that cycle. Waiters are
// served in arrival order. Writing initial_value (address 0) reloads the
// count and empties the wait queue; do so only while no request is pending.
module fair_counting_semaphore
  import fcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [ID_W-1:0]      requester_id,
  output logic                 done,
  output logic [STATUS_W-1:0]  status,
  output logic [ID_W-1:0]      grant_id,
  output logic [WAITING_W-1:0] waiting,
  output logic [15:0]          count_now,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic             init_sel;
  logic             init_write;
  logic [CFG_W-1:0] initial_value;
  dp_cmd_t          cmd;
  dp_flags_t        flags;

  // Register decode; the only register answers wherever paddr[2] is low (addresses 0 to 3).
  assign pready     = 1'b1;
  assign init_sel   = ~paddr[2];
  assign init_write = psel & penable & pwrite & pready & init_sel;
  assign prdata     = init_sel ? 32'(initial_value) : '0;

  // Initial-value register.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= INIT_RESET;
    end else if (init_write) begin
      initial_value <= pwdata[CFG_W-1:0];
    end
  end

  fcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .cmd   (cmd)
  );

  fcs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .reload       (init_write),
    .reload_value (pwdata[CFG_W-1:0]),
    .req_type     (req_type),
    .requester_id (requester_id),
    .flags        (flags),
    .done         (done),
    .status       (status),
    .grant_id     (grant_id),
    .waiting      (waiting),
    .count_now    (count_now)
  );

endmodule

// ----- hw/rtl/fcs_ctrl.sv -----
// Controller state machine that decodes each request into datapath commands.
module fcs_ctrl
  import fcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_flags_t flags,
  output logic      busy,
  output dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.result   = RES_GRANTED;
    busy         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
        if (flags.req_type == REQ_ACQUIRE) begin
          // Acquire: grant from the count, else join the queue if it has room.
          if (!flags.count_zero) begin
            cmd.dec    = 1'b1;
            cmd.result = RES_GRANTED;
          end else if (flags.queue_full) begin
            cmd.result = RES_FULL;
          end else begin
            cmd.push   = 1'b1;
            cmd.result = RES_QUEUED;
          end
        end else begin
          // Release: hand over to the oldest waiter, else raise the count unless it is at its maximum.
          if (!flags.queue_empty) begin
            cmd.pop    = 1'b1;
            cmd.result = RES_PASSED;
          end else if (flags.count_max) begin
            cmd.result = RES_AT_MAX;
          end else begin
            cmd.inc    = 1'b1;
            cmd.result = RES_INCR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fcs_datapath.sv -----
// Datapath with the count, the wait queue and the result registers.
module fcs_datapath
  import fcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic                 reload,
  input  logic [CFG_W-1:0]     reload_value,
  input  logic                 req_type,
  input  logic [ID_W-1:0]      requester_id,
  output dp_flags_t            flags,
  output logic                 done,
  output logic [STATUS_W-1:0]  status,
  output logic [ID_W-1:0]      grant_id,
  output logic [WAITING_W-1:0] waiting,
  output logic [15:0]          count_now
);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      head_next;
  logic [PTR_W-1:0]      tail;
  logic [PTR_W-1:0]      tail_next;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic                  req_kind;
  logic [ID_W-1:0]       req_id;
  logic [ID_W-1:0]       head_id;
  logic [ID_W-1:0]       grant_next;
  logic [ID_W-1:0]       queue_mem [MAX_WAITERS];

  // Pointer advance with wrap at the queue depth.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    begin
      if (p == PTR_W'(MAX_WAITERS - 1)) begin
        res = '0;
      end else begin
        res = p + PTR_W'(1);
      end
      return res;
    end
  endfunction

  // Status for the controller.
  assign flags.req_type    = req_kind;
  assign flags.count_zero  = (count == '0);
  assign flags.count_max   = (count == CNT_MAX);
  assign flags.queue_full  = (fill == FILL_W'(MAX_WAITERS));
  assign flags.queue_empty = (fill == '0);

  // Next values of the count and the queue bookkeeping.
  always_comb begin
    count_next = count;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    grant_next = '0;
    if (cmd.dec) begin
      count_next = count - COUNT_BITS'(1);
      grant_next = req_id;
    end
    if (cmd.inc) begin
      count_next = count + COUNT_BITS'(1);
    end
    if (cmd.push) begin
      tail_next = advance(tail);
      fill_next = fill + FILL_W'(1);
    end
    if (cmd.pop) begin
      head_next  = advance(head);
      fill_next  = fill - FILL_W'(1);
      grant_next = head_id;
    end
  end

  // Request capture at the accepted transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind <= req_type;
      req_id   <= requester_id;
    end
  end

  // Wait queue storage; the oldest entry is read as a request is taken.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      queue_mem[tail] <= req_id;
    end
    if (cmd.load_req) begin
      head_id <= queue_mem[head];
    end
  end

  // Count and pointers; a register write reloads them.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= load_count(INIT_RESET);
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (reload) begin
      count <= load_count(reload_value);
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status    <= cmd.result;
      grant_id  <= grant_next;
      waiting   <= WAITING_W'(fill_next);
      count_now <= 16'(count_next);
    end
  end

endmodule

// ----- hw/rtl/fcs_checker.sv -----
// Port-level checker for the semaphore and its bind to the top level.
`include "fair_counting_semaphore_macros.svh"

module fcs_checker
  import fcs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [STATUS_W-1:0]  status,
  input logic [WAITING_W-1:0] waiting,
  input logic [15:0]          count_now
);

  // Every result comes from a request transfer, through the execute state and the done register.
  `FCS_ASSERT_SAME(a_done_from_request, done, $past(start && !busy, 2), "result without request")

  // The controller is busy in the cycle after a request transfer.
  `FCS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "request not held off")

  // A full-queue rejection only happens with every slot taken.
  `FCS_ASSERT_SAME(a_full_means_full, done && (status == RES_FULL),
    waiting == WAITING_W'(MAX_WAITERS), "queue full reported with free slots")

  // A requester is queued only when the count is exhausted.
  `FCS_ASSERT_SAME(a_queued_count_zero, done && (status == RES_QUEUED),
    count_now == '0, "requester queued while count available")

  // Saturation is reported only at the top of the count.
  `FCS_ASSERT_SAME(a_at_max_saturated, done && (status == RES_AT_MAX),
    count_now == 16'(CNT_MAX), "count at max reported below maximum")

endmodule

bind fair_counting_semaphore fcs_checker u_fcs_checker (.*);

// ----- tb/fair_counting_semaphore_test.sv -----
// Testbench for the fair counting semaphore: request stimulus, register writes and result checks.
`timescale 1ns / 1ps

module fair_counting_semaphore_test;
  import fcs_pkg::*;

  // One result transfer as the block should produce it.
  typedef struct {
    result_t          status;
    logic [ID_W-1:0]  grant;
    logic [WAITING_W-1:0] waiting;
    logic [15:0]      count;
  } sem_result_t;

  // Shadow copy of the semaphore: predicts each result and checks what the block returns.
  class grant_tracker;
    logic [COUNT_BITS-1:0] count;
    logic [ID_W-1:0]       ring [MAX_WAITERS];
    logic [PTR_W-1:0]      head;
    logic [PTR_W-1:0]      tail;
    logic [FILL_W-1:0]     fill;
    sem_result_t           pending_results[$];
    int                    errors;
    int                    results_seen;
    int                    status_seen[6];

    function new();
      errors = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      reload(INIT_RESET);
    endfunction

    // A write of the initial value reloads the count and empties the queue.
    function void reload(logic [CFG_W-1:0] v);
      count = v;
      head = '0;
      tail = '0;
      fill = '0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Works out the result of one accepted request and updates the shadow state.
    function void note_request(logic kind, logic [ID_W-1:0] id);
      sem_result_t r;
      r.grant = '0;
      if (kind == REQ_ACQUIRE) begin
        if (count != '0) begin
          count = count - 1'b1;
          r.status = RES_GRANTED;
          r.grant = id;
        end else if (fill == MAX_WAITERS) begin
          r.status = RES_FULL;
        end else begin
          ring[tail] = id;
          tail = tail + 1'b1;
          fill = fill + 1'b1;
          r.status = RES_QUEUED;
        end
      end else begin
        if (fill != '0) begin
          r.grant = ring[head];
          head = head + 1'b1;
          fill = fill - 1'b1;
          r.status = RES_PASSED;
        end else if (count == CNT_MAX) begin
          r.status = RES_AT_MAX;
        end else begin
          count = count + 1'b1;
          r.status = RES_INCR;
        end
      end
      r.waiting = fill;
      r.count = count;
      pending_results.push_back(r);
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] gid,
                               logic [WAITING_W-1:0] w, logic [15:0] c);
      sem_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, status %0d", $time, st);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      results_seen++;
      status_seen[int'(e.status)]++;
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (gid !== e.grant) begin
        $display("%0t: grant_id expected %0d actual %0d", $time, e.grant, gid);
        errors++;
      end
      if (w !== e.waiting) begin
        $display("%0t: waiting expected %0d actual %0d", $time, e.waiting, w);
        errors++;
      end
      if (c !== e.count) begin
        $display("%0t: count_now expected %0d actual %0d", $time, e.count, c);
        errors++;
      end
    endfunction
  endclass

  localparam logic [2:0] ADDR_INITIAL = 3'd0;
  localparam logic [2:0] ADDR_UNUSED  = 3'd4;
  localparam int         CYCLE_LIMIT  = 400000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 req_type;
  logic [ID_W-1:0]      requester_id;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      grant_id;
  logic [WAITING_W-1:0] waiting;
  logic [15:0]          count_now;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  grant_tracker tracker;
  int           requests_sent;
  int           settings_used;
  int           cycles;

  fair_counting_semaphore uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .requester_id (requester_id),
    .done         (done),
    .status       (status),
    .grant_id     (grant_id),
    .waiting      (waiting),
    .count_now    (count_now),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every result transfer is taken in the cycle it appears.
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result(status, grant_id, waiting, count_now);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fair_counting_semaphore: mismatch");
      $finish;
    end
  end

  // One register access: setup cycle, then access cycle until pready.
  task automatic reg_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Loads a new initial value, with junk in the unused upper data bits, and reads it back.
  task automatic set_initial_value(input logic [15:0] v);
    logic [31:0] rd;
    reg_cycle(1'b1, ADDR_INITIAL, {16'($urandom), v}, rd);
    tracker.reload(v);
    settings_used++;
    reg_cycle(1'b0, ADDR_INITIAL, 32'd0, rd);
    if (rd !== {16'd0, v}) begin
      $display("%0t: initial_value read expected %0d actual %0d", $time, v, rd);
      tracker.errors++;
    end
  endtask

  // Offers one request and holds it until the block takes the transfer.
  task automatic send_request(input logic kind, input logic [ID_W-1:0] id);
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    requester_id <= id;
    do @(posedge clk); while (busy);
    tracker.note_request(kind, id);
    requests_sent++;
  endtask

  // Idle cycles on the request side, with noise on the fields.
  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      req_type <= 1'($urandom);
      requester_id <= ID_W'($urandom);
    end
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic finish_outstanding();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic in bursts; the acquire share steers how deep the queue gets.
  task automatic run_phase(input int acquire_pct, input int items, input logic pause_midway);
    int   sent;
    int   burst;
    int   k;
    logic kind;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < items; k++) begin
        kind = ($urandom_range(0, 99) < acquire_pct) ? REQ_ACQUIRE : REQ_RELEASE;
        send_request(kind, ID_W'($urandom_range(0, 15)));
        sent++;
        if (pause_midway && sent == items / 2) finish_outstanding();
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [31:0] rd;
    logic [15:0] inits [9];
    int          shares [9];
    int          p;
    int          i;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ACQUIRE;
    requester_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    requests_sent = 0;
    settings_used = 1;
    tracker = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The initial value comes out of reset as one.
    reg_cycle(1'b0, ADDR_INITIAL, 32'd0, rd);
    if (rd !== 32'(INIT_RESET)) begin
      $display("%0t: initial_value after reset expected %0d actual %0d", $time,
               INIT_RESET, rd);
      tracker.errors++;
    end

    // Take the only unit, queue every id, overflow the queue, then hand two grants on.
    send_request(REQ_ACQUIRE, 4'd5);
    for (i = 0; i < MAX_WAITERS; i++) send_request(REQ_ACQUIRE, ID_W'(i));
    send_request(REQ_ACQUIRE, 4'd10);
    send_request(REQ_RELEASE, 4'd15);
    send_request(REQ_RELEASE, 4'd0);
    finish_outstanding();

    // Reload at the top of the range while waiters remain; the queue must be emptied.
    set_initial_value(16'hFFFF);
    send_request(REQ_RELEASE, 4'd3);
    send_request(REQ_ACQUIRE, 4'd15);
    send_request(REQ_RELEASE, 4'd0);
    finish_outstanding();

    // A write outside the register map changes nothing.
    reg_cycle(1'b1, ADDR_UNUSED, 32'd0, rd);
    send_request(REQ_RELEASE, 4'd9);
    finish_outstanding();

    // Random phases over several initial values, extremes included.
    inits[0] = 16'd0;      shares[0] = 55;
    inits[1] = 16'd1;      shares[1] = 50;
    inits[2] = 16'd2;      shares[2] = 68;
    inits[3] = 16'd3;      shares[3] = 45;
    inits[4] = 16'hFFFF;   shares[4] = 40;
    inits[5] = 16'hFFFE;   shares[5] = 55;
    inits[6] = 16'($urandom_range(4, 30));   shares[6] = $urandom_range(55, 75);
    inits[7] = 16'($urandom);                shares[7] = $urandom_range(35, 65);
    inits[8] = 16'd0;      shares[8] = 62;
    for (p = 0; p < 9; p++) begin
      set_initial_value(inits[p]);
      run_phase(shares[p], 120, p % 3 == 1);
      finish_outstanding();
    end

    $display("Sent %0d requests across %0d initial-value settings.", requests_sent,
             settings_used);
    $display("Results: granted %0d, queued %0d, passed %0d, incremented %0d, full %0d, max %0d",
             tracker.status_seen[RES_GRANTED], tracker.status_seen[RES_QUEUED],
             tracker.status_seen[RES_PASSED], tracker.status_seen[RES_INCR],
             tracker.status_seen[RES_FULL], tracker.status_seen[RES_AT_MAX]);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("fair_counting_semaphore: match");
    end else begin
      $display("fair_counting_semaphore: mismatch");
    end
    $finish;
  end

endmodule
